### src/scfp_pkg.sv
// Shared types and constants for the servo command frame packer.
`timescale 1ns / 1ps
`default_nettype none
package scfp_pkg;

  localparam int NumCh    = 6;
  localparam int PulseW   = 14;
  localparam int DigitW   = 7;
  localparam int ServoLen = 22;
  localparam int TestLen  = 16;
  localparam int CntW     = 5;

  // Reciprocal of 100 scaled by 2^19; exact for pulses below 43699.
  localparam int RecipW     = 13;
  localparam int RecipShift = 19;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;
  localparam int ProdW = PulseW + RecipW;

  // Request kinds
  localparam logic KindLink  = 1'b0;
  localparam logic KindServo = 1'b1;

  localparam logic [7:0] SyncByte    = 8'hAA;
  localparam logic [7:0] LenByte     = 8'h12;
  localparam logic [7:0] ChIdBase    = 8'hB1;
  localparam logic [7:0] TestHead    = 8'h55;
  localparam logic [7:0] TestTail    = 8'h5A;
  // Low byte of the sum of the six channel ids 0xB1..0xB6.
  localparam logic [7:0] IdSumLow    = 8'h35;
  localparam logic [7:0] Hundred     = 8'd100;

  typedef logic [7:0] octet_t;
  typedef logic [NumCh-1:0][DigitW-1:0] digits_t;
  typedef logic [NumCh-1:0][7:0] dsums_t;

  typedef struct packed {
    logic load;
    logic servo;
  } frm_ctrl_t;

endpackage
`default_nettype wire

### src/scfp_lane.sv
// Digit lane: splits one pulse width into its two base-100 digit pairs.
`timescale 1ns / 1ps
`default_nettype none
module scfp_lane (
  input  wire logic                          clk,
  input  wire logic                          ld1,
  input  wire logic                          ld2,
  input  wire logic [scfp_pkg::PulseW-1:0]   pulse,
  output logic      [scfp_pkg::DigitW-1:0]   lo_digit,
  output logic      [scfp_pkg::DigitW-1:0]   hi_digit,
  output logic      [7:0]                    dsum
);

  logic [scfp_pkg::ProdW-1:0]  prod_r, prod_nxt;
  logic [scfp_pkg::PulseW-1:0] pulse_r, pulse_nxt;
  logic [scfp_pkg::DigitW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [7:0]                  dsum_r, dsum_nxt;
  logic [7:0]                  quot;
  logic [scfp_pkg::PulseW-1:0] rem;

  // Stage one: multiply by the scaled reciprocal of 100
  always_comb begin
    prod_nxt  = scfp_pkg::ProdW'(pulse) * scfp_pkg::ProdW'(scfp_pkg::Recip100);
    pulse_nxt = pulse;
  end

  // Stage two: quotient, remainder, and wrap of the high pair
  always_comb begin
    quot     = prod_r[scfp_pkg::RecipShift +: 8];
    rem      = pulse_r - scfp_pkg::PulseW'(quot) * scfp_pkg::PulseW'(scfp_pkg::Hundred);
    lo_nxt   = rem[scfp_pkg::DigitW-1:0];
    hi_nxt   = (quot >= scfp_pkg::Hundred) ? scfp_pkg::DigitW'(quot - scfp_pkg::Hundred)
                                           : quot[scfp_pkg::DigitW-1:0];
    dsum_nxt = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  end

  // Hold each stage until its load strobe
  always_ff @(posedge clk) begin
    if (ld1) begin
      prod_r  <= prod_nxt;
      pulse_r <= pulse_nxt;
    end
    if (ld2) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      dsum_r <= dsum_nxt;
    end
  end

  assign lo_digit = lo_r;
  assign hi_digit = hi_r;
  assign dsum     = dsum_r;

endmodule
`default_nettype wire

### src/scfp_framer.sv
// Merge stage: builds the frame from the lane digits and shifts it out a byte per cycle.
`timescale 1ns / 1ps
`default_nettype none
module scfp_framer (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire scfp_pkg::frm_ctrl_t   ctrl,
  input  wire scfp_pkg::digits_t     lo_digits,
  input  wire scfp_pkg::digits_t     hi_digits,
  input  wire scfp_pkg::dsums_t      dsums,
  output logic                       free,
  output logic                       strobe,
  output logic [7:0]                 byte_o,
  output logic                       last
);

  scfp_pkg::octet_t frame_r   [scfp_pkg::ServoLen];
  scfp_pkg::octet_t frame_nxt [scfp_pkg::ServoLen];
  scfp_pkg::octet_t frame_ld  [scfp_pkg::ServoLen];
  logic [scfp_pkg::CntW-1:0] left_r, left_nxt;
  logic [7:0] csum;

  // Sum the channel bytes: ids are a constant, digits come from the lanes
  always_comb begin
    csum = scfp_pkg::IdSumLow;
    for (int c = 0; c < scfp_pkg::NumCh; c++) begin
      csum = csum + dsums[c];
    end
  end

  // Assemble the frame to load
  always_comb begin
    for (int i = 0; i < scfp_pkg::ServoLen; i++) begin
      frame_ld[i] = '0;
    end
    if (ctrl.servo) begin
      frame_ld[0] = scfp_pkg::SyncByte;
      frame_ld[1] = scfp_pkg::SyncByte;
      frame_ld[2] = scfp_pkg::LenByte;
      for (int c = 0; c < scfp_pkg::NumCh; c++) begin
        frame_ld[3 + 3*c] = scfp_pkg::ChIdBase + 8'(c);
        frame_ld[4 + 3*c] = {1'b0, lo_digits[c]};
        frame_ld[5 + 3*c] = {1'b0, hi_digits[c]};
      end
      frame_ld[scfp_pkg::ServoLen-1] = ~csum;
    end else begin
      frame_ld[0]                   = scfp_pkg::TestHead;
      frame_ld[scfp_pkg::TestLen-1] = scfp_pkg::TestTail;
    end
  end

  // Load a new frame or advance the shift line
  always_comb begin
    frame_nxt = frame_r;
    left_nxt  = left_r;
    if (ctrl.load) begin
      frame_nxt = frame_ld;
      left_nxt  = ctrl.servo ? scfp_pkg::CntW'(scfp_pkg::ServoLen)
                             : scfp_pkg::CntW'(scfp_pkg::TestLen);
    end else if (left_r != '0) begin
      for (int i = 0; i < scfp_pkg::ServoLen - 1; i++) begin
        frame_nxt[i] = frame_r[i+1];
      end
      left_nxt = left_r - scfp_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  assign strobe = (left_r != '0);
  assign last   = (left_r == scfp_pkg::CntW'(1));
  assign free   = (left_r == '0) || last;
  assign byte_o = frame_r[0];

endmodule
`default_nettype wire

### src/servo_command_frame_packer_top.sv
// Servo command frame packer: request intake, six digit lanes and the frame shifter.
// A request passes lane stages one and two, then its frame loads into the shifter.
// Throughput: one byte per cycle; a servo frame is 22 bytes, a link test 16, and
// frames follow back to back as the next request waits in the lane stages.
// busy is high while a request sits in the two lane stages.
// Reset (rst_n low, synchronous) drops any request in flight and any frame being sent.
`timescale 1ns / 1ps
`default_nettype none
module servo_command_frame_packer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_kind,
  input  wire logic [scfp_pkg::PulseW-1:0]   in_pulse_ch1,
  input  wire logic [scfp_pkg::PulseW-1:0]   in_pulse_ch2,
  input  wire logic [scfp_pkg::PulseW-1:0]   in_pulse_ch3,
  input  wire logic [scfp_pkg::PulseW-1:0]   in_pulse_ch4,
  input  wire logic [scfp_pkg::PulseW-1:0]   in_pulse_ch5,
  input  wire logic [scfp_pkg::PulseW-1:0]   in_pulse_ch6,
  output logic                               out_strobe,
  output logic [7:0]                         out_byte,
  output logic                               out_last_byte
);

  logic v1_r, v1_nxt, v2_r, v2_nxt;
  logic kind1_r, kind2_r;
  logic accept;
  logic frm_free;
  logic frm_load;
  logic [scfp_pkg::NumCh-1:0][scfp_pkg::PulseW-1:0] pulses;
  scfp_pkg::digits_t lo_digits, hi_digits;
  scfp_pkg::dsums_t  dsums;
  scfp_pkg::frm_ctrl_t frm_ctrl;

  assign pulses = {in_pulse_ch6, in_pulse_ch5, in_pulse_ch4,
                   in_pulse_ch3, in_pulse_ch2, in_pulse_ch1};

  // Take a request only when both lane stages are empty
  assign busy     = v1_r | v2_r;
  assign accept   = start & ~busy;
  assign frm_load = v2_r & frm_free;

  // Advance the request through the lane stages; hold it in stage two until the shifter frees
  always_comb begin
    v1_nxt = accept;
    v2_nxt = v1_r | (v2_r & ~frm_free);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind1_r <= in_kind;
    end
    if (v1_r) begin
      kind2_r <= kind1_r;
    end
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // One lane per servo channel
  for (genvar c = 0; c < scfp_pkg::NumCh; c++) begin : g_lane
    scfp_lane u_lane (
      .clk      (clk),
      .ld1      (accept),
      .ld2      (v1_r),
      .pulse    (pulses[c]),
      .lo_digit (lo_digits[c]),
      .hi_digit (hi_digits[c]),
      .dsum     (dsums[c])
    );
  end

  assign frm_ctrl.load  = frm_load;
  assign frm_ctrl.servo = kind2_r;

  scfp_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (frm_ctrl),
    .lo_digits (lo_digits),
    .hi_digits (hi_digits),
    .dsums     (dsums),
    .free      (frm_free),
    .strobe    (out_strobe),
    .byte_o    (out_byte),
    .last      (out_last_byte)
  );

  // Only one request may be in the lane stages at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(v1_r && v2_r))
    else $error("two requests in the lane stages");

  // A frame loads only when the shifter is idle or on its final byte
  a_load_gap: assert property (@(posedge clk) disable iff (!rst_n)
    frm_load |-> (!out_strobe || out_last_byte))
    else $error("frame loaded over a frame still being sent");

  // A loaded frame shows its first byte in the next cycle
  a_load_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    frm_load |=> (out_strobe && !out_last_byte))
    else $error("loaded frame did not start");

  // A taken request passes stage one and then reaches stage two
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 v2_r)
    else $error("request lost in the lane stages");

endmodule
`default_nettype wire
